>>> src/tevq_pkg.sv
// Package holding the request and result codes and the controller interface types.
`timescale 1ns / 1ps
package tevq_pkg;

    localparam logic [2:0] OP_POST       = 3'd0;
    localparam logic [2:0] OP_CANCEL_ID  = 3'd1;
    localparam logic [2:0] OP_CANCEL_OBJ = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_ADVANCE    = 3'd4;

    localparam logic [2:0] KIND_POSTED    = 3'd0;
    localparam logic [2:0] KIND_CANCELLED = 3'd1;
    localparam logic [2:0] KIND_QUERY     = 3'd2;
    localparam logic [2:0] KIND_DUE       = 3'd3;
    localparam logic [2:0] KIND_DONE      = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    // Slot record: fire time, start time, id, object tag, event code.
    localparam int SLOT_W = 128;

    typedef struct packed {
        logic       latch;
        logic       scan_clear;
        logic       scan_rd;
        logic       emit;
        logic [2:0] emit_kind;
    } tevq_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       post_err;
        logic       adv_err;
        logic       found;
        logic       out_free;
    } tevq_status_t;

endpackage

>>> src/tevq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tevq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/tevq_datapath.sv
// Datapath: clock and id registers, slot store, scan compare and result register.
`timescale 1ns / 1ps
module tevq_datapath
    import tevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tevq_cmd_t                      cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] scan_addr,
    output tevq_status_t                   status,
    input  logic [2:0]                     operation,
    input  logic [31:0]                    fire_time,
    input  logic                           post_now,
    input  logic [15:0]                    event_code,
    input  logic [15:0]                    object_tag,
    input  logic [31:0]                    event_id,
    input  logic [31:0]                    target_time,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     result_kind,
    output logic [31:0]                    result_id,
    output logic [15:0]                    result_object,
    output logic [15:0]                    result_code,
    output logic                           is_pending,
    output logic [31:0]                    time_left,
    output logic [31:0]                    scheduled_duration,
    output logic [31:0]                    time_since_post,
    output logic [31:0]                    clock_now,
    output logic                           last
);

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [31:0] cur_time_reg, cur_time_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;

    logic [2:0]  op_reg;
    logic [31:0] fire_reg, qid_reg, target_reg;
    logic        now_reg;
    logic [15:0] code_reg, tag_reg;

    logic          proc_reg, proc_next;
    logic [IW-1:0] proc_idx_reg;

    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [31:0]   best_fire_reg, best_fire_next;
    logic [31:0]   best_start_reg, best_start_next;
    logic [31:0]   best_age_reg, best_age_next;
    logic [31:0]   best_id_reg, best_id_next;
    logic [15:0]   best_obj_reg, best_obj_next;
    logic [15:0]   best_code_reg, best_code_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg;
    logic [31:0] rid_reg, tleft_reg, dur_reg, since_reg, clk_now_reg;
    logic [15:0] robj_reg, rcode_reg;
    logic        pend_reg, last_reg;

    logic [IW-1:0]     free_idx;
    logic              full;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;
    logic [31:0]       post_fire;
    logic [31:0]       s_fire, s_start, s_id, s_age;
    logic [15:0]       s_obj, s_code;
    logic              s_valid;

    assign post_fire = now_reg ? cur_time_reg : fire_reg;
    assign full      = &valid_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign ram_we    = cmd.emit && (cmd.emit_kind == KIND_POSTED);
    assign ram_wdata = {post_fire, cur_time_reg, next_id_reg, tag_reg, code_reg};

    tevq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (ram_wdata),
        .re    (cmd.scan_rd),
        .raddr (scan_addr),
        .rdata (ram_rdata)
    );

    assign {s_fire, s_start, s_id, s_obj, s_code} = ram_rdata;
    assign s_valid = valid_reg[proc_idx_reg];
    assign s_age   = next_id_reg - s_id;

    assign status.op       = op_reg;
    assign status.post_err = (!now_reg && (fire_reg < cur_time_reg)) || full;
    assign status.adv_err  = target_reg < cur_time_reg;
    assign status.found    = found_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cur_time_next   = cur_time_reg;
        next_id_next    = next_id_reg;
        valid_next      = valid_reg;
        proc_next       = cmd.scan_rd;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_fire_next  = best_fire_reg;
        best_start_next = best_start_reg;
        best_age_next   = best_age_reg;
        best_id_next    = best_id_reg;
        best_obj_next   = best_obj_reg;
        best_code_next  = best_code_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (proc_reg && s_valid)
        begin
            case (op_reg)
                OP_CANCEL_ID:
                begin
                    if (s_id == qid_reg)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                    end
                end
                OP_CANCEL_OBJ:
                begin
                    if (s_obj == tag_reg)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                    end
                end
                OP_QUERY:
                begin
                    if ((s_id == qid_reg) && !found_reg)
                    begin
                        found_next      = 1'b1;
                        best_fire_next  = s_fire;
                        best_start_next = s_start;
                    end
                end
                OP_ADVANCE:
                begin
                    if ((s_fire <= target_reg) &&
                        (!found_reg || (s_fire < best_fire_reg) ||
                         ((s_fire == best_fire_reg) && (s_age < best_age_reg))))
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = proc_idx_reg;
                        best_fire_next = s_fire;
                        best_age_next  = s_age;
                        best_id_next   = s_id;
                        best_obj_next  = s_obj;
                        best_code_next = s_code;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_clear)
        begin
            found_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            case (cmd.emit_kind)
                KIND_POSTED:
                begin
                    valid_next[free_idx] = 1'b1;
                    next_id_next         = next_id_reg + 32'd1;
                end
                KIND_DUE:
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    cur_time_next            = best_fire_reg;
                end
                KIND_DONE:
                begin
                    cur_time_next = target_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg  <= '0;
            next_id_reg   <= 32'd1;
            valid_reg     <= '0;
            proc_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_time_reg  <= cur_time_next;
            next_id_reg   <= next_id_next;
            valid_reg     <= valid_next;
            proc_reg      <= proc_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= operation;
            fire_reg   <= fire_time;
            now_reg    <= post_now;
            code_reg   <= event_code;
            tag_reg    <= object_tag;
            qid_reg    <= event_id;
            target_reg <= target_time;
        end
        proc_idx_reg   <= scan_addr;
        best_idx_reg   <= best_idx_next;
        best_fire_reg  <= best_fire_next;
        best_start_reg <= best_start_next;
        best_age_reg   <= best_age_next;
        best_id_reg    <= best_id_next;
        best_obj_reg   <= best_obj_next;
        best_code_reg  <= best_code_next;
        if (cmd.emit)
        begin
            kind_reg    <= cmd.emit_kind;
            rid_reg     <= '0;
            robj_reg    <= '0;
            rcode_reg   <= '0;
            pend_reg    <= 1'b0;
            tleft_reg   <= '0;
            dur_reg     <= '0;
            since_reg   <= '0;
            clk_now_reg <= cur_time_next;
            last_reg    <= cmd.emit_kind != KIND_DUE;
            case (cmd.emit_kind)
                KIND_POSTED:
                begin
                    rid_reg <= next_id_reg;
                end
                KIND_DUE:
                begin
                    rid_reg   <= best_id_reg;
                    robj_reg  <= best_obj_reg;
                    rcode_reg <= best_code_reg;
                end
                KIND_QUERY:
                begin
                    if (found_reg)
                    begin
                        pend_reg  <= 1'b1;
                        tleft_reg <= best_fire_reg - cur_time_reg;
                        dur_reg   <= best_fire_reg - best_start_reg;
                        since_reg <= cur_time_reg - best_start_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign result_kind        = kind_reg;
    assign result_id          = rid_reg;
    assign result_object      = robj_reg;
    assign result_code        = rcode_reg;
    assign is_pending         = pend_reg;
    assign time_left          = tleft_reg;
    assign scheduled_duration = dur_reg;
    assign time_since_post    = since_reg;
    assign clock_now          = clk_now_reg;
    assign last               = last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded while the output register is still occupied");

    a_due_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_kind == KIND_DUE)) |=> !valid_reg[$past(best_idx_reg)])
        else $error("due event still stored after it was emitted");

    a_post_id: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_kind == KIND_POSTED)) |=>
            (next_id_reg == $past(next_id_reg) + 32'd1))
        else $error("id counter did not step after a post");

    a_due_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_kind == KIND_DUE)) |-> found_reg)
        else $error("due event emitted without a scan hit");

endmodule

>>> src/tevq_ctrl.sv
// Controller state machine sequencing requests, slot scans and result emission.
`timescale 1ns / 1ps
module tevq_ctrl
    import tevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tevq_status_t                   status,
    output tevq_cmd_t                      cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0] scan_addr
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    assign in_stall  = state_reg != S_IDLE;
    assign scan_addr = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.op inside {OP_CANCEL_ID, OP_CANCEL_OBJ, OP_QUERY} ||
                    ((status.op == OP_ADVANCE) && !status.adv_err))
                begin
                    cmd.scan_clear = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_SCAN;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = ((status.op == OP_POST) && !status.post_err) ?
                                    KIND_POSTED : KIND_ERROR;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    case (status.op)
                        OP_QUERY:
                        begin
                            cmd.emit_kind = KIND_QUERY;
                        end
                        OP_ADVANCE:
                        begin
                            if (status.found)
                            begin
                                cmd.emit_kind  = KIND_DUE;
                                cmd.scan_clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                            else
                            begin
                                cmd.emit_kind = KIND_DONE;
                            end
                        end
                        default:
                        begin
                            cmd.emit_kind = KIND_CANCELLED;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/timed_event_queue_core.sv
// Top level of the timed event queue: controller and datapath joined by commands.
//
//  Channel | Handshake           | Contents
//  in      | in_valid / in_stall   | one request: operation and its arguments
//  out     | out_valid / out_stall | one result; last marks the end of a request
//
//  A post or an error is answered without a scan; cancel and query scan every slot once.
//  An advance scans every slot again after each due event it emits, then ends with done.
//  The slot scan reads one slot of the store per cycle.
//  Reset empties the store, sets the clock to zero and the next id to one.
//  A result that out_stall holds back delays the request until the output register is free.
//  in_stall stays high until the request has ended.
`timescale 1ns / 1ps
module timed_event_queue_core
    import tevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [31:0] fire_time,
    input  logic        post_now,
    input  logic [15:0] event_code,
    input  logic [15:0] object_tag,
    input  logic [31:0] event_id,
    input  logic [31:0] target_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [31:0] result_id,
    output logic [15:0] result_object,
    output logic [15:0] result_code,
    output logic        is_pending,
    output logic [31:0] time_left,
    output logic [31:0] scheduled_duration,
    output logic [31:0] time_since_post,
    output logic [31:0] clock_now,
    output logic        last
);

    tevq_cmd_t                      cmd;
    tevq_status_t                   status;
    logic [$clog2(QUEUE_DEPTH)-1:0] scan_addr;

    tevq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    tevq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .scan_addr          (scan_addr),
        .status             (status),
        .operation          (operation),
        .fire_time          (fire_time),
        .post_now           (post_now),
        .event_code         (event_code),
        .object_tag         (object_tag),
        .event_id           (event_id),
        .target_time        (target_time),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .result_kind        (result_kind),
        .result_id          (result_id),
        .result_object      (result_object),
        .result_code        (result_code),
        .is_pending         (is_pending),
        .time_left          (time_left),
        .scheduled_duration (scheduled_duration),
        .time_since_post    (time_since_post),
        .clock_now          (clock_now),
        .last               (last)
    );

endmodule
